// ----- rtl/bpfe_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfe_pkg
// Shared types and constants of the first-fit buffer pool with idle eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfe_pkg;

  localparam int unsigned THR_BITS   = 16;
  localparam int unsigned IDLE_BITS  = 16;
  localparam logic [THR_BITS-1:0] THR_RESET = 16'd3;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_REUSED    = 3'd0,
    ST_CREATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_TICKED    = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_FIN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/buffer_pool_first_fit_evict_core.sv -----
// ----------------------------------------------------------------------------
// buffer_pool_first_fit_evict_core
// Ordered buffer pool: first-fit acquire, release by handle, idle ageing with
// in-order compaction on tick, and clear.
//
// Requests enter on the s_axis channel (tuser = action, tdata = usage, size,
// release handle) and one result leaves per request on m_axis (tuser =
// status, tdata = handle, evicted, pool count). The threshold register is
// written on the cfg channel, which is always ready.
// Pool entries sit in one RAM. A small sequencer walks them in order, each
// entry read and then evaluated against the single compare and update path,
// writing back or compacting through the RAM write port. A new request is
// taken only once the previous one is through; the scan covers up to
// POOL_DEPTH entries, stops early on an acquire or release that hits, and is
// skipped by a clear. The result turns valid as s_axis_tready rises again and
// sits in an output register, so the next request is accepted while it waits;
// a stalled receiver holds the sequencer only where a further result would
// have to be loaded.
// Reset empties the pool, zeroes the handle counter and sets the threshold
// to 3. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_first_fit_evict_core #(
  parameter int unsigned POOL_DEPTH  = 16,
  parameter int unsigned SIZE_BITS   = 32,
  parameter int unsigned USAGE_BITS  = 8,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire [bpfe_pkg::THR_BITS-1:0]          cfg_data_i,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // usage, size, release_handle
  input  wire [((USAGE_BITS+SIZE_BITS+HANDLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  wire [1:0]                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // handle, evicted, pool_count
  output logic [((HANDLE_BITS+2*$clog2(POOL_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [2:0]                            m_axis_tuser
);

  localparam int unsigned ADDR_W    = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W     = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IDLE_BITS = bpfe_pkg::IDLE_BITS;
  localparam int unsigned OUT_BITS  = HANDLE_BITS + 2 * CNT_W;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned E_W       = USAGE_BITS + SIZE_BITS + 1 + IDLE_BITS + HANDLE_BITS;
  localparam int unsigned I_LSB     = HANDLE_BITS;
  localparam int unsigned B_POS     = I_LSB + IDLE_BITS;
  localparam int unsigned S_LSB     = B_POS + 1;
  localparam int unsigned U_LSB     = S_LSB + SIZE_BITS;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);

  bpfe_pkg::state_e  state_q, state_d;
  bpfe_pkg::action_e act_q, act_d;
  bpfe_pkg::status_e res_status_q, res_status_d, out_status_q, out_status_d;

  logic [bpfe_pkg::THR_BITS-1:0] thr_q;
  logic [USAGE_BITS-1:0]  usage_q, usage_d;
  logic [SIZE_BITS-1:0]   size_q, size_d;
  logic [HANDLE_BITS-1:0] rel_q, rel_d;
  logic [CNT_W-1:0]       len_q, len_d, idx_q, idx_d, kept_q, kept_d, ev_q, ev_d;
  logic [HANDLE_BITS-1:0] nh_q, nh_d;
  logic [HANDLE_BITS-1:0] res_handle_q, res_handle_d, out_handle_q, out_handle_d;
  logic [CNT_W-1:0]       res_ev_q, res_ev_d, out_ev_q, out_ev_d, out_cnt_q, out_cnt_d;
  logic                   out_valid_q, out_valid_d;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [E_W-1:0]         ram_wdata, ram_rdata;

  logic [USAGE_BITS-1:0]  r_usage;
  logic [SIZE_BITS-1:0]   r_size;
  logic                   r_busy;
  logic [IDLE_BITS-1:0]   r_idle, idle_inc;
  logic [HANDLE_BITS-1:0] r_handle;
  logic [CNT_W-1:0]       idx_nxt;
  logic                   last, drop, out_free;

  assign r_handle = ram_rdata[HANDLE_BITS-1:0];
  assign r_idle   = ram_rdata[I_LSB +: IDLE_BITS];
  assign r_busy   = ram_rdata[B_POS];
  assign r_size   = ram_rdata[S_LSB +: SIZE_BITS];
  assign r_usage  = ram_rdata[U_LSB +: USAGE_BITS];
  assign idle_inc = (r_idle == {IDLE_BITS{1'b1}}) ? r_idle : r_idle + IDLE_BITS'(1);
  assign drop     = !r_busy && (idle_inc >= thr_q);
  assign idx_nxt  = idx_q + CNT_W'(1);
  assign last     = (idx_nxt == len_q);
  assign out_free = !out_valid_q || m_axis_tready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == bpfe_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_W'({out_cnt_q, out_ev_q, out_handle_q});

  bpfe_ram #(
    .WIDTH(E_W),
    .DEPTH(POOL_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    usage_d      = usage_q;
    size_d       = size_q;
    rel_d        = rel_q;
    len_d        = len_q;
    idx_d        = idx_q;
    kept_d       = kept_q;
    ev_d         = ev_q;
    nh_d         = nh_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_ev_d     = res_ev_q;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_ev_d     = out_ev_q;
    out_cnt_d    = out_cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[ADDR_W-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[ADDR_W-1:0];

    case (state_q)
      bpfe_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d        = bpfe_pkg::action_e'(s_axis_tuser);
          usage_d      = s_axis_tdata[USAGE_BITS-1:0];
          size_d       = s_axis_tdata[USAGE_BITS +: SIZE_BITS];
          rel_d        = s_axis_tdata[USAGE_BITS+SIZE_BITS +: HANDLE_BITS];
          idx_d        = '0;
          kept_d       = '0;
          ev_d         = '0;
          res_handle_d = '0;
          res_ev_d     = '0;
          if (bpfe_pkg::action_e'(s_axis_tuser) == bpfe_pkg::ACT_CLEAR) begin
            len_d        = '0;
            res_status_d = bpfe_pkg::ST_CLEARED;
            state_d      = bpfe_pkg::S_DONE;
          end else if (len_q == '0) begin
            state_d = bpfe_pkg::S_FIN;
          end else begin
            state_d = bpfe_pkg::S_RD;
          end
        end
      end
      bpfe_pkg::S_RD: begin
        ram_re  = 1'b1;
        state_d = bpfe_pkg::S_EV;
      end
      bpfe_pkg::S_EV: begin
        idx_d   = idx_nxt;
        state_d = last ? bpfe_pkg::S_FIN : bpfe_pkg::S_RD;
        case (act_q)
          bpfe_pkg::ACT_ACQUIRE: begin
            if (!r_busy && r_usage == usage_q && r_size >= size_q) begin
              ram_we       = 1'b1;
              ram_wdata    = {r_usage, r_size, 1'b1, {IDLE_BITS{1'b0}}, r_handle};
              res_status_d = bpfe_pkg::ST_REUSED;
              res_handle_d = r_handle;
              state_d      = bpfe_pkg::S_DONE;
            end
          end
          bpfe_pkg::ACT_RELEASE: begin
            if (r_handle == rel_q) begin
              ram_we       = 1'b1;
              ram_wdata    = {r_usage, r_size, 1'b0, r_idle, r_handle};
              res_status_d = bpfe_pkg::ST_RELEASED;
              state_d      = bpfe_pkg::S_DONE;
            end
          end
          bpfe_pkg::ACT_TICK: begin
            if (drop) begin
              ev_d = ev_q + CNT_W'(1);
            end else begin
              ram_we    = 1'b1;
              ram_waddr = kept_q[ADDR_W-1:0];
              ram_wdata = {r_usage, r_size, r_busy, r_busy ? r_idle : idle_inc, r_handle};
              kept_d    = kept_q + CNT_W'(1);
            end
          end
          default: begin
            state_d = bpfe_pkg::S_FIN;
          end
        endcase
      end
      bpfe_pkg::S_FIN: begin
        state_d = bpfe_pkg::S_DONE;
        case (act_q)
          bpfe_pkg::ACT_ACQUIRE: begin
            if (len_q < DEPTH_C) begin
              ram_we       = 1'b1;
              ram_waddr    = len_q[ADDR_W-1:0];
              ram_wdata    = {usage_q, size_q, 1'b1, {IDLE_BITS{1'b0}}, nh_q};
              res_status_d = bpfe_pkg::ST_CREATED;
              res_handle_d = nh_q;
              nh_d         = nh_q + HANDLE_BITS'(1);
              len_d        = len_q + CNT_W'(1);
            end else begin
              res_status_d = bpfe_pkg::ST_FULL;
            end
          end
          bpfe_pkg::ACT_RELEASE: begin
            res_status_d = bpfe_pkg::ST_NOT_FOUND;
          end
          bpfe_pkg::ACT_TICK: begin
            res_status_d = bpfe_pkg::ST_TICKED;
            res_ev_d     = ev_q;
            len_d        = kept_q;
          end
          default: begin
            res_status_d = bpfe_pkg::ST_CLEARED;
            len_d        = '0;
          end
        endcase
      end
      bpfe_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          out_ev_d     = res_ev_q;
          out_cnt_d    = len_q;
          state_d      = bpfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpfe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpfe_pkg::S_IDLE;
      len_q       <= '0;
      nh_q        <= '0;
      thr_q       <= bpfe_pkg::THR_RESET;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      kept_q      <= '0;
      ev_q        <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      nh_q        <= nh_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      ev_q        <= ev_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    usage_q      <= usage_d;
    size_q       <= size_d;
    rel_q        <= rel_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_ev_q     <= res_ev_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_ev_q     <= out_ev_d;
    out_cnt_q    <= out_cnt_d;
  end

  // pool never grows past its depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= DEPTH_C)
    else $error("pool length beyond depth");

  // compaction writes never overtake the scan
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpfe_pkg::S_EV && act_q == bpfe_pkg::ACT_TICK) |->
      (kept_q <= idx_q && kept_q + ev_q == idx_q))
    else $error("compaction ahead of scan");

  // an accepted request keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // a waiting result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_handle_q)))
    else $error("stalled result lost");

endmodule

`default_nettype wire

// ----- rtl/bpfe_ram.sv -----
// ----------------------------------------------------------------------------
// bpfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire [WIDTH-1:0]                 wdata_i,
  input  wire                             re_i,
  input  wire [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for buffer_pool_first_fit_evict_core. Requests go in on
// s_axis with bursty gaps, results are taken on m_axis under a changing stall
// pattern and compared in order against a local model of the pool. Covers the
// directed corner cases, pool full, zero and maximum thresholds, a long
// receiver hold-off, back-to-back streaming and several random phases.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int          DEPTH     = 16;
  localparam int          LONG_HOLD = 600;
  localparam int unsigned CYC_LIMIT = 4000000;

  typedef struct packed {
    bpfe_pkg::status_e st;
    logic [15:0]       hdl;
    logic [4:0]        evc;
    logic [4:0]        cnt;
  } pool_rsp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [55:0] s_axis_tdata  = '0;   // usage [7:0], size [39:8], release_handle [55:40]
  logic [1:0]  s_axis_tuser  = '0;   // action
  logic        m_axis_tready = 1'b0;
  wire         cfg_ready_o;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;         // handle [15:0], evicted [20:16], pool_count [25:21]
  wire  [2:0]  m_axis_tuser;         // status

  buffer_pool_first_fit_evict_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // pool model
  logic [7:0]  m_usage [DEPTH];
  logic [31:0] m_size  [DEPTH];
  logic        m_busy  [DEPTH];
  logic [15:0] m_idle  [DEPTH];
  logic [15:0] m_hdl   [DEPTH];
  int          m_len   = 0;
  logic [15:0] nxt_hdl = '0;
  logic [15:0] thr     = bpfe_pkg::THR_RESET;

  pool_rsp_t   rsp_due_q [$];
  int          err_cnt   = 0;
  int unsigned cyc_cnt   = 0;
  int          burst_left = 0;
  bit          fast_tx   = 1'b0;
  logic        fast_rx   = 1'b0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          rdy_pct   = 100;

  function automatic pool_rsp_t pool_apply(input bpfe_pkg::action_e act,
                                           input logic [7:0] usg,
                                           input logic [31:0] sz, input logic [15:0] rel);
    pool_rsp_t r;
    int        i;
    int        kept;
    bit        hit;
    bit        drop;
    r.st  = bpfe_pkg::ST_CLEARED;
    r.hdl = '0;
    r.evc = '0;
    hit   = 1'b0;
    case (act)
      bpfe_pkg::ACT_ACQUIRE: begin
        for (i = 0; i < m_len && !hit; i++) begin
          if (!m_busy[i] && m_usage[i] == usg && m_size[i] >= sz) begin
            m_busy[i] = 1'b1;
            m_idle[i] = '0;
            r.st      = bpfe_pkg::ST_REUSED;
            r.hdl     = m_hdl[i];
            hit       = 1'b1;
          end
        end
        if (!hit && m_len < DEPTH) begin
          m_usage[m_len] = usg;
          m_size[m_len]  = sz;
          m_busy[m_len]  = 1'b1;
          m_idle[m_len]  = '0;
          m_hdl[m_len]   = nxt_hdl;
          r.hdl          = nxt_hdl;
          r.st           = bpfe_pkg::ST_CREATED;
          nxt_hdl        = nxt_hdl + 16'd1;
          m_len++;
        end else if (!hit) begin
          r.st = bpfe_pkg::ST_FULL;
        end
      end
      bpfe_pkg::ACT_RELEASE: begin
        r.st = bpfe_pkg::ST_NOT_FOUND;
        for (i = 0; i < m_len && !hit; i++) begin
          if (m_hdl[i] == rel) begin
            m_busy[i] = 1'b0;
            r.st      = bpfe_pkg::ST_RELEASED;
            hit       = 1'b1;
          end
        end
      end
      bpfe_pkg::ACT_TICK: begin
        kept = 0;
        for (i = 0; i < m_len; i++) begin
          drop = 1'b0;
          if (!m_busy[i]) begin
            if (m_idle[i] != 16'hFFFF) m_idle[i] = m_idle[i] + 16'd1;
            if (m_idle[i] >= thr) drop = 1'b1;
          end
          if (drop) begin
            r.evc = r.evc + 5'd1;
          end else begin
            m_usage[kept] = m_usage[i];
            m_size[kept]  = m_size[i];
            m_busy[kept]  = m_busy[i];
            m_idle[kept]  = m_idle[i];
            m_hdl[kept]   = m_hdl[i];
            kept++;
          end
        end
        m_len = kept;
        r.st  = bpfe_pkg::ST_TICKED;
      end
      default: begin
        m_len = 0;
      end
    endcase
    r.cnt = m_len[4:0];
    return r;
  endfunction

  // one request, with sender bursts and gaps
  task automatic pool_req(input bpfe_pkg::action_e act, input logic [7:0] usg,
                          input logic [31:0] sz, input logic [15:0] rel);
    int gap;
    if (!fast_tx && burst_left == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rel, sz, usg};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rsp_due_q.push_back(pool_apply(act, usg, sz, rel));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [15:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    thr = v;
  endtask

  task automatic send_rand_req(input int acq_pct);
    int          r;
    int          j;
    logic [7:0]  usg;
    logic [31:0] sz;
    logic [15:0] rel;
    usg = 8'($urandom);
    sz  = $urandom;
    rel = 16'($urandom);
    r   = $urandom_range(99);
    if (r < acq_pct) begin
      if (m_len != 0 && $urandom_range(1) == 1) begin
        j   = $urandom_range(m_len - 1);
        usg = m_usage[j];
        case ($urandom_range(3))
          0:       sz = m_size[j];
          1:       sz = m_size[j] - $urandom_range(3);
          2:       sz = m_size[j] + $urandom_range(1, 3);
          default: sz = $urandom_range(m_size[j]);
        endcase
      end else begin
        case ($urandom_range(4))
          0:       usg = 8'h00;
          1:       usg = 8'hFF;
          2:       usg = 8'h01;
          3:       usg = 8'h80;
          default: ;
        endcase
        case ($urandom_range(3))
          0:       sz = '0;
          1:       sz = '1;
          2:       ;
          default: sz = $urandom_range(4096);
        endcase
      end
      pool_req(bpfe_pkg::ACT_ACQUIRE, usg, sz, rel);
    end else if (r < acq_pct + (100 - acq_pct) * 3 / 5) begin
      case ($urandom_range(4))
        0:       rel = nxt_hdl - 16'd1;
        1:       rel = nxt_hdl;
        2:       ;
        default: if (m_len != 0) rel = m_hdl[$urandom_range(m_len - 1)];
      endcase
      pool_req(bpfe_pkg::ACT_RELEASE, usg, sz, rel);
    end else if (r < 98) begin
      pool_req(bpfe_pkg::ACT_TICK, usg, sz, rel);
    end else begin
      pool_req(bpfe_pkg::ACT_CLEAR, usg, sz, rel);
    end
  endtask

  task automatic test_basic();
    logic [15:0] h0;
    logic [15:0] h1;
    logic [15:0] h2;
    logic [15:0] h3;
    h0 = nxt_hdl;
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h00, 32'd0, 16'h0000);
    h1 = nxt_hdl;
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h00, 32'd0, 16'hFFFF);  // first one busy, so a new one
    pool_req(bpfe_pkg::ACT_RELEASE, 8'hFF, 32'hFFFFFFFF, h0);
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, h0);         // already free
    h2 = nxt_hdl;
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h00, 32'hFFFFFFFF, 16'h0000);  // too small, new entry
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h00, 32'd0, 16'h0000);         // reuse first
    h3 = nxt_hdl;
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'hFF, 32'hFFFFFFFF, 16'h0000);
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, h3);
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'hFE, 32'd1, 16'h0000);         // usage differs
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'hFF, 32'hFFFFFFFF, 16'h0000);  // exact reuse at max
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, 16'hFFFF);         // unknown handle
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, h1);
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, h2);
    pool_req(bpfe_pkg::ACT_TICK, 8'hFF, 32'hFFFFFFFF, 16'hFFFF);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, h0);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);            // two reach three
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h00, 32'd5, 16'h0000);
    pool_req(bpfe_pkg::ACT_CLEAR, 8'hFF, 32'hFFFFFFFF, 16'hFFFF);
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, h0);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);            // empty pool
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h55, 32'hAAAAAAAA, 16'h5555);  // counter kept
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'hAA, 32'h55555555, 16'hAAAA);
  endtask

  task automatic test_pool_full();
    int i;
    set_threshold(16'hFFFF);
    pool_req(bpfe_pkg::ACT_CLEAR, 8'h00, 32'd0, 16'h0000);
    for (i = 0; i < DEPTH; i++) begin
      pool_req(bpfe_pkg::ACT_ACQUIRE, 8'(i), 32'(i * 64), 16'h0000);
    end
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h99, 32'd1, 16'h0000);
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, m_hdl[7]);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h07, 32'd500, 16'h0000);   // too big, still full
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h07, 32'd448, 16'h0000);   // reuse while full
  endtask

  task automatic test_zero_threshold();
    int i;
    set_threshold(16'd0);
    for (i = 0; i < 8; i += 2) pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, m_hdl[i]);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);
    pool_req(bpfe_pkg::ACT_CLEAR, 8'h00, 32'd0, 16'h0000);
  endtask

  task automatic test_backpressure();
    set_threshold(16'd4);
    hold_reqs <= hold_reqs + 1;
    repeat (60) send_rand_req(60);
  endtask

  task automatic test_random();
    int          ph;
    int          ap;
    logic [15:0] th;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin th = 16'd1;                      ap = 50; end
        1:       begin th = 16'd0;                      ap = 45; end
        2:       begin th = 16'hFFFF;                   ap = 70; end
        3:       begin th = 16'd2;                      ap = 45; end
        4:       begin th = 16'($urandom_range(4, 40)); ap = 60; end
        default: begin th = bpfe_pkg::THR_RESET;        ap = 50; end
      endcase
      set_threshold(th);
      repeat (290) send_rand_req(ap);
    end
  endtask

  // sender and receiver without gaps, then a short mixed tail
  task automatic test_back_to_back();
    int i;
    set_threshold(16'd2);
    fast_tx = 1'b1;
    fast_rx <= 1'b1;
    pool_req(bpfe_pkg::ACT_CLEAR, 8'h00, 32'd0, 16'h0000);
    repeat (40) begin
      pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h33, 32'd9, 16'h0000);
      pool_req(bpfe_pkg::ACT_CLEAR, 8'h00, 32'd0, 16'h0000);
    end
    fast_tx = 1'b0;
    fast_rx <= 1'b0;
    for (i = 0; i < 4; i++) begin
      pool_req(bpfe_pkg::ACT_ACQUIRE, 8'(8'h10 + i), 32'd100, 16'h0000);
    end
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, nxt_hdl - 16'd2);
    pool_req(bpfe_pkg::ACT_ACQUIRE, 8'h12, 32'd100, 16'h0000);
    pool_req(bpfe_pkg::ACT_RELEASE, 8'h00, 32'd0, 16'hFFFF);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);
    pool_req(bpfe_pkg::ACT_TICK, 8'h00, 32'd0, 16'h0000);
  endtask

  // receiver: stall pattern in modes, long hold on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen     <= hold_reqs;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(20, 200);
        case ($urandom_range(3))
          0:       rdy_pct <= 100;
          1:       rdy_pct <= 70;
          2:       rdy_pct <= 30;
          default: rdy_pct <= 5;
        endcase
      end else begin
        mode_left <= mode_left - 1;
      end
      m_axis_tready <= fast_rx || ($urandom_range(99) < rdy_pct);
    end
  end

  always @(posedge clk_i) begin
    pool_rsp_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rsp_due_q.size() == 0) begin
        $display("%0t: unexpected result st=%0d hdl=%h evc=%0d cnt=%0d", $time,
                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[20:16], m_axis_tdata[25:21]);
        err_cnt++;
      end else begin
        e = rsp_due_q.pop_front();
        if (m_axis_tuser !== e.st || m_axis_tdata[15:0] !== e.hdl ||
            m_axis_tdata[20:16] !== e.evc || m_axis_tdata[25:21] !== e.cnt) begin
          $display("%0t: mismatch exp st=%0d hdl=%h evc=%0d cnt=%0d got st=%0d hdl=%h evc=%0d cnt=%0d",
                   $time, e.st, e.hdl, e.evc, e.cnt, m_axis_tuser, m_axis_tdata[15:0],
                   m_axis_tdata[20:16], m_axis_tdata[25:21]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYC_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic();
    test_pool_full();
    test_zero_threshold();
    test_backpressure();
    test_random();
    test_back_to_back();
    drain_results();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && rsp_due_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
